/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files; included by tensor_vector_reorient.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_AT(lbl, clk, rst_n, !(expr), msg)
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hw/rtl/tvr_pkg.sv */
// shared constants and types of the tensor / vector reorientation block
`default_nettype none
package tvr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF = 18;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TENSOR_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_OUTPUT = 3'd5;

    // rotation row reset values, packed bits
    localparam logic [63:0] ROT_ROW0_RST = 64'd131072;
    localparam logic [63:0] ROT_ROW1_RST = 64'd17179869184;
    localparam logic [63:0] ROT_ROW2_RST = 64'd2251799813685248;

    // stage enables of one dot-product lane
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } lane_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/tvr_if.sv */
// valid/ready channel interfaces: voxel input, result output, configuration write
`default_nettype none
interface tvr_in_if #(parameter int DATA_WIDTH = tvr_pkg::DATA_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] comp0;
    logic signed [DATA_WIDTH-1:0] comp1;
    logic signed [DATA_WIDTH-1:0] comp2;
    logic signed [DATA_WIDTH-1:0] comp3;
    logic signed [DATA_WIDTH-1:0] comp4;
    logic signed [DATA_WIDTH-1:0] comp5;
    logic                         on_border;

    modport source (output valid, comp0, comp1, comp2, comp3, comp4, comp5, on_border,
                    input ready);
    modport sink (input valid, comp0, comp1, comp2, comp3, comp4, comp5, on_border,
                  output ready);
endinterface

interface tvr_out_if #(parameter int DATA_WIDTH = tvr_pkg::DATA_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res0;
    logic signed [DATA_WIDTH-1:0] res1;
    logic signed [DATA_WIDTH-1:0] res2;
    logic signed [DATA_WIDTH-1:0] res3;
    logic signed [DATA_WIDTH-1:0] res4;
    logic signed [DATA_WIDTH-1:0] res5;

    modport source (output valid, res0, res1, res2, res3, res4, res5, input ready);
    modport sink (input valid, res0, res1, res2, res3, res4, res5, output ready);
endinterface

interface tvr_cfg_if #(parameter int COEF_WIDTH = tvr_pkg::COEF_WIDTH_DEF);
    logic                           valid;
    logic                           ready;
    logic [tvr_pkg::CFG_IDX_W-1:0]  index;
    logic [3*COEF_WIDTH-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tensor_vector_reorient.sv */
// top level: per-voxel tensor R*H*R^T or vector R*v reorientation
//
//  channel | role   | transaction carries
//  --------+--------+-------------------------------------------------
//  voxel   | sink   | comp0..comp5, on_border
//  result  | source | res0..res5
//  cfg     | sink   | index, data (register write, always ready)
//
// one voxel per cycle sustained while result.ready stays high
// stages: input capture, first product, first sum (H*R^T), second product,
// second sum (R*T), merge/output register; each stage holds while the
// next one is full and cannot move, so bubbles are squeezed out
// reset loads the rotation reset rows, flip 0, tensor mode, abs off, and empties
// the pipeline; no clearing pass is needed
`default_nettype none
`include "assert_macros.svh"
module tensor_vector_reorient #(
    parameter int DATA_WIDTH = tvr_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = tvr_pkg::COEF_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tvr_in_if.sink    voxel,
    tvr_out_if.source result,
    tvr_cfg_if.sink   cfg
);
    localparam int ROT_W = 3 * COEF_WIDTH;
    localparam int HW    = DATA_WIDTH + 1;   // room for a negated minimum input
    localparam int TW    = DATA_WIDTH + 3;   // intermediate tensor width
    localparam int FRAC  = COEF_WIDTH - 2;
    localparam int NSTG  = 6;

    // symmetric tensor element index for row/col, and result row/col
    localparam int SYM_IDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
    localparam int RES_ROW [6]    = '{0, 0, 0, 1, 1, 2};
    localparam int RES_COL [6]    = '{0, 1, 2, 1, 2, 2};

    // configuration registers
    logic [ROT_W-1:0] rot_row_reg [3];
    logic [2:0]       flip_mask_reg;
    logic             tensor_mode_reg;
    logic             abs_output_reg;

    logic signed [COEF_WIDTH-1:0] coef [3][3];

    // pipeline control
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] en;

    // stage 0 payload
    logic signed [HW-1:0] h_reg [6];
    logic signed [HW-1:0] h_next [6];
    logic                 neg_xy;
    logic                 neg_xz;
    logic                 neg_yz;

    // border flag travels alongside stages 0..4
    logic [4:0] border_reg;

    // first-pass results and the vector copy that waits for the merge
    logic signed [TW-1:0] t_val [3][3];
    logic signed [TW-1:0] vec_d3_reg [3];
    logic signed [TW-1:0] vec_d4_reg [3];

    logic signed [DATA_WIDTH-1:0] tens_res [6];
    logic signed [DATA_WIDTH-1:0] res_q [6];

    tvr_pkg::lane_ctl_t ctl_a;
    tvr_pkg::lane_ctl_t ctl_b;

    //--------------------------------------------------------------------
    // configuration writes
    //--------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_reg[0]  <= ROT_W'(tvr_pkg::ROT_ROW0_RST);
            rot_row_reg[1]  <= ROT_W'(tvr_pkg::ROT_ROW1_RST);
            rot_row_reg[2]  <= ROT_W'(tvr_pkg::ROT_ROW2_RST);
            flip_mask_reg   <= 3'b000;
            tensor_mode_reg <= 1'b1;
            abs_output_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                tvr_pkg::REG_ROT_ROW0:    rot_row_reg[0]  <= cfg.data;
                tvr_pkg::REG_ROT_ROW1:    rot_row_reg[1]  <= cfg.data;
                tvr_pkg::REG_ROT_ROW2:    rot_row_reg[2]  <= cfg.data;
                tvr_pkg::REG_FLIP_MASK:   flip_mask_reg   <= cfg.data[2:0];
                tvr_pkg::REG_TENSOR_MODE: tensor_mode_reg <= cfg.data[0];
                tvr_pkg::REG_ABS_OUTPUT:  abs_output_reg  <= cfg.data[0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // unpack signed Q2.x rotation entries, column 0 lowest
    for (genvar r = 0; r < 3; r++)
    begin : g_coef_row
        for (genvar c = 0; c < 3; c++)
        begin : g_coef_col
            assign coef[r][c] = rot_row_reg[r][c*COEF_WIDTH +: COEF_WIDTH];
        end
    end

    //--------------------------------------------------------------------
    // stage enables: a stage loads when empty or when the next one moves
    //--------------------------------------------------------------------
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || result.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? voxel.valid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign voxel.ready  = en[0];
    assign result.valid = v_reg[NSTG-1];

    //--------------------------------------------------------------------
    // stage 0: capture, off-diagonal sign flips in tensor mode only
    // (vector mode reuses row 0 of the first pass as R*v)
    //--------------------------------------------------------------------
    always_comb
    begin
        neg_xy = tensor_mode_reg && (flip_mask_reg[0] ^ flip_mask_reg[1]);
        neg_xz = tensor_mode_reg && (flip_mask_reg[0] ^ flip_mask_reg[2]);
        neg_yz = tensor_mode_reg && (flip_mask_reg[1] ^ flip_mask_reg[2]);
        h_next[0] = HW'(voxel.comp0);
        h_next[1] = neg_xy ? -HW'(voxel.comp1) : HW'(voxel.comp1);
        h_next[2] = neg_xz ? -HW'(voxel.comp2) : HW'(voxel.comp2);
        h_next[3] = HW'(voxel.comp3);
        h_next[4] = neg_yz ? -HW'(voxel.comp4) : HW'(voxel.comp4);
        h_next[5] = HW'(voxel.comp5);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            h_reg <= h_next;
        end
    end

    // border flag shift, stage k loads with en[k]
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            border_reg[0] <= voxel.on_border;
        end
        for (int k = 1; k < 5; k++)
        begin
            if (en[k])
            begin
                border_reg[k] <= border_reg[k-1];
            end
        end
    end

    //--------------------------------------------------------------------
    // first pass: nine lanes, T[a][b] = sum_p H[a][p] * R[b][p]
    //--------------------------------------------------------------------
    assign ctl_a.mul_en = en[1];
    assign ctl_a.sum_en = en[2];

    for (genvar a = 0; a < 3; a++)
    begin : g_lane_a_row
        for (genvar b = 0; b < 3; b++)
        begin : g_lane_a_col
            logic signed [HW-1:0]         a_sel [3];
            logic signed [COEF_WIDTH-1:0] b_sel [3];

            always_comb
            begin
                for (int p = 0; p < 3; p++)
                begin
                    a_sel[p] = h_reg[SYM_IDX[a][p]];
                    b_sel[p] = coef[b][p];
                end
            end

            tvr_dot3 #(
                .A_WIDTH   (HW),
                .B_WIDTH   (COEF_WIDTH),
                .FRAC_BITS (FRAC),
                .SAT_WIDTH (TW)
            ) u_lane_a (
                .clk (clk),
                .ctl (ctl_a),
                .a   (a_sel),
                .b   (b_sel),
                .dot (t_val[a][b])
            );
        end
    end

    // row 0 of the first pass is the vector result, delayed to the merge
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            vec_d3_reg <= t_val[0];
        end
        if (en[4])
        begin
            vec_d4_reg <= vec_d3_reg;
        end
    end

    //--------------------------------------------------------------------
    // second pass: six lanes, res(a,b) = sum_p R[a][p] * T[p][b]
    //--------------------------------------------------------------------
    assign ctl_b.mul_en = en[3];
    assign ctl_b.sum_en = en[4];

    for (genvar i = 0; i < 6; i++)
    begin : g_lane_b
        logic signed [COEF_WIDTH-1:0] a_sel [3];
        logic signed [TW-1:0]         b_sel [3];

        always_comb
        begin
            for (int p = 0; p < 3; p++)
            begin
                a_sel[p] = coef[RES_ROW[i]][p];
                b_sel[p] = t_val[p][RES_COL[i]];
            end
        end

        tvr_dot3 #(
            .A_WIDTH   (COEF_WIDTH),
            .B_WIDTH   (TW),
            .FRAC_BITS (FRAC),
            .SAT_WIDTH (DATA_WIDTH)
        ) u_lane_b (
            .clk (clk),
            .ctl (ctl_b),
            .a   (a_sel),
            .b   (b_sel),
            .dot (tens_res[i])
        );
    end

    //--------------------------------------------------------------------
    // merge and output register
    //--------------------------------------------------------------------
    tvr_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .clk         (clk),
        .en          (en[NSTG-1]),
        .tens_res    (tens_res),
        .vec_sum     (vec_d4_reg),
        .border      (border_reg[4]),
        .tensor_mode (tensor_mode_reg),
        .abs_output  (abs_output_reg),
        .res         (res_q)
    );

    assign result.res0 = res_q[0];
    assign result.res1 = res_q[1];
    assign result.res2 = res_q[2];
    assign result.res3 = res_q[3];
    assign result.res4 = res_q[4];
    assign result.res5 = res_q[5];

    //--------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------
    `ASSERT_AT(a_accept_fills_stage0, clk, rst_n,
        voxel.valid && voxel.ready |=> v_reg[0], "accepted transaction lost at stage 0")
    `ASSERT_NEVER(a_backpressure_only_when_full, clk, rst_n,
        !voxel.ready && !(&v_reg), "input stalled while pipeline has a bubble")
    `ASSERT_AT(a_vector_upper_zero, clk, rst_n,
        result.valid && !tensor_mode_reg |->
            result.res3 == '0 && result.res4 == '0 && result.res5 == '0,
        "vector mode result has nonzero upper components")
    `ASSERT_AT(a_abs_nonnegative, clk, rst_n,
        result.valid && !tensor_mode_reg && abs_output_reg |->
            !result.res0[DATA_WIDTH-1] && !result.res1[DATA_WIDTH-1] && !result.res2[DATA_WIDTH-1],
        "absolute value output is negative")
endmodule
`default_nettype wire

/* hw/rtl/tvr_dot3.sv */
// one lane: three-term dot product, rounded and saturated, two register stages
`default_nettype none
module tvr_dot3 #(
    parameter int A_WIDTH   = tvr_pkg::DATA_WIDTH_DEF + 1,
    parameter int B_WIDTH   = tvr_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS = tvr_pkg::COEF_WIDTH_DEF - 2,
    parameter int SAT_WIDTH = tvr_pkg::DATA_WIDTH_DEF + 3
) (
    input  wire logic                         clk,
    input  wire tvr_pkg::lane_ctl_t           ctl,
    input  wire logic signed [A_WIDTH-1:0]    a [3],
    input  wire logic signed [B_WIDTH-1:0]    b [3],
    output logic signed [SAT_WIDTH-1:0]       dot
);
    localparam int PROD_W = A_WIDTH + B_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0]    prod_reg [3];
    logic signed [SUM_W-1:0]     sum_w;
    logic signed [SUM_W-1:0]     rnd;
    logic                        ovf;
    logic signed [SAT_WIDTH-1:0] dot_next;
    logic signed [SAT_WIDTH-1:0] dot_reg;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            for (int p = 0; p < 3; p++)
            begin
                prod_reg[p] <= a[p] * b[p];
            end
        end
    end

    // stage 2: exact sum, round half up, saturate
    always_comb
    begin
        sum_w = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]) + HALF;
        rnd   = sum_w >>> FRAC_BITS;
        ovf   = !((&rnd[SUM_W-1:SAT_WIDTH-1]) || !(|rnd[SUM_W-1:SAT_WIDTH-1]));
        if (ovf)
        begin
            dot_next = {rnd[SUM_W-1], {(SAT_WIDTH-1){~rnd[SUM_W-1]}}};
        end
        else
        begin
            dot_next = rnd[SAT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;
endmodule
`default_nettype wire

/* hw/rtl/tvr_merge.sv */
// merge stage: picks tensor or vector lanes, abs option, border zeroing, output register
`default_nettype none
module tvr_merge #(
    parameter int DATA_WIDTH = tvr_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [DATA_WIDTH-1:0]  tens_res [6],
    input  wire logic signed [DATA_WIDTH+2:0]  vec_sum [3],
    input  wire logic                          border,
    input  wire logic                          tensor_mode,
    input  wire logic                          abs_output,
    output logic signed [DATA_WIDTH-1:0]       res [6]
);
    localparam int VW = DATA_WIDTH + 4;

    logic signed [VW-1:0]         mag [3];
    logic signed [DATA_WIDTH-1:0] vec_res [3];
    logic signed [DATA_WIDTH-1:0] res_next [6];
    logic signed [DATA_WIDTH-1:0] res_reg [6];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = VW'(vec_sum[i]);
            if (abs_output && vec_sum[i][DATA_WIDTH+2])
            begin
                mag[i] = -mag[i];
            end
            if ((&mag[i][VW-1:DATA_WIDTH-1]) || !(|mag[i][VW-1:DATA_WIDTH-1]))
            begin
                vec_res[i] = mag[i][DATA_WIDTH-1:0];
            end
            else
            begin
                vec_res[i] = {mag[i][VW-1], {(DATA_WIDTH-1){~mag[i][VW-1]}}};
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            if (border)
            begin
                res_next[i] = '0;
            end
            else if (tensor_mode)
            begin
                res_next[i] = tens_res[i];
            end
            else if (i < 3)
            begin
                res_next[i] = vec_res[i % 3];
            end
            else
            begin
                res_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire
